>>> hdl/sat_pkg.sv
// Shared constants, codes and types of the section address translator.
`timescale 1ns / 1ps

package sat_pkg;

	localparam int unsigned MAX_SECTIONS = 16;
	localparam int unsigned IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int unsigned CNT_W        = 5;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned QUEUE_DEPTH  = 2;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_V2R  = 2'd1;
	localparam logic [1:0] OP_R2V  = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_V2R,
		CMD_R2V
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_EVAL,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] a;   // virtual base for loads, address for translates
		logic [DATA_W-1:0] b;   // raw base for loads
	} item_t;

endpackage

>>> hdl/sat_in_if.sv
// Input channel: valid/ready handshake with load and translate fields.
`timescale 1ns / 1ps

interface sat_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  entry_index;
	logic [31:0] virtual_base;
	logic [31:0] raw_base;
	logic [31:0] address;

	modport source (output valid, output opcode, output entry_index, output virtual_base,
		output raw_base, output address, input ready);
	modport sink (input valid, input opcode, input entry_index, input virtual_base,
		input raw_base, input address, output ready);
endinterface

>>> hdl/sat_out_if.sv
// Output channel: valid/ready handshake carrying the translated address.
`timescale 1ns / 1ps

interface sat_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] translated;

	modport source (output valid, output translated, input ready);
	modport sink (input valid, input translated, output ready);
endinterface

>>> hdl/sat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sat_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/sat_front.sv
// Front end: accepts input transactions, drops unused ones, classifies the rest.
`timescale 1ns / 1ps

module sat_front (
	sat_in_if.sink        in_ch,
	output logic          push_valid,
	input  logic          push_ready,
	output sat_pkg::item_t push_item
);
	import sat_pkg::*;

	logic keep;

	always_comb begin
		keep            = 1'b0;
		push_item.cmd   = CMD_LOAD;
		push_item.idx   = IDX_W'(in_ch.entry_index);
		push_item.a     = in_ch.address;
		push_item.b     = in_ch.raw_base;
		unique case (in_ch.opcode)
			OP_LOAD: begin
				keep        = (int'(in_ch.entry_index) < MAX_SECTIONS);
				push_item.a = in_ch.virtual_base;
			end
			OP_V2R: begin
				keep          = 1'b1;
				push_item.cmd = CMD_V2R;
			end
			OP_R2V: begin
				keep          = 1'b1;
				push_item.cmd = CMD_R2V;
			end
			default: keep = 1'b0;
		endcase
	end

	// dropped transactions are still taken, so ready follows the queue only
	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid && keep;

endmodule

>>> hdl/sat_queue.sv
// Short FIFO between the front end and the back end.
`timescale 1ns / 1ps

module sat_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sat_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output sat_pkg::item_t pop_item
);
	import sat_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	item_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push_fire;
	logic          pop_fire;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow push");

endmodule

>>> hdl/sat_back.sv
// Back end: section table, sequential range scan and result register.
`timescale 1ns / 1ps

module sat_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [sat_pkg::CNT_W-1:0]   cfg_wr_data,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  sat_pkg::item_t              pop_item,
	sat_out_if.source                   out_ch
);
	import sat_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  last_idx;
	logic [DATA_W-1:0] addr_q;
	cmd_t              dir_q;
	logic              prev_ge_q;
	logic [DATA_W-1:0] prev_from_q;
	logic [DATA_W-1:0] prev_to_q;
	logic [DATA_W-1:0] result_q;
	logic [DATA_W-1:0] result_d;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_raddr;
	logic [2*DATA_W-1:0] ram_rdata;

	logic [DATA_W-1:0] from_k;
	logic [DATA_W-1:0] to_k;
	logic              ge_k;
	logic              first;
	logic              last;
	logic              bypass;
	logic              hit;
	logic [DATA_W-1:0] sel_from;
	logic [DATA_W-1:0] sel_to;
	logic              pop_fire;

	sat_ram #(
		.WIDTH (2 * DATA_W),
		.DEPTH (MAX_SECTIONS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pop_item.idx),
		.wdata ({pop_item.a, pop_item.b}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (count_q == '0) begin
			last_idx = '0;
		end else if (int'(count_q) > MAX_SECTIONS) begin
			last_idx = IDX_W'(MAX_SECTIONS - 1);
		end else begin
			last_idx = IDX_W'(count_q - 1'b1);
		end
	end

	// entry layout: virtual base high, raw base low
	assign from_k = (dir_q == CMD_V2R) ? ram_rdata[2*DATA_W-1:DATA_W] : ram_rdata[DATA_W-1:0];
	assign to_k   = (dir_q == CMD_V2R) ? ram_rdata[DATA_W-1:0] : ram_rdata[2*DATA_W-1:DATA_W];
	assign ge_k   = (addr_q >= from_k);
	assign first  = (idx_q == '0);
	assign last   = (idx_q == last_idx);
	assign bypass = first && !ge_k;

	// section k-1 closes when entry k is seen; the last section stays open
	always_comb begin
		hit      = 1'b0;
		sel_from = prev_from_q;
		sel_to   = prev_to_q;
		if (last && ge_k) begin
			hit      = 1'b1;
			sel_from = from_k;
			sel_to   = to_k;
		end else if (!first && prev_ge_q && !ge_k) begin
			hit = 1'b1;
		end
		if (bypass) begin
			result_d = addr_q;
		end else if (hit) begin
			result_d = sel_to + (addr_q - sel_from);
		end else begin
			result_d = result_q;
		end
	end

	assign pop_fire = pop_valid && pop_ready;

	always_comb begin
		state_d      = state_q;
		pop_ready    = 1'b0;
		ram_we       = 1'b0;
		ram_raddr    = idx_q;
		out_ch.valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					if (pop_item.cmd == CMD_LOAD) begin
						ram_we = 1'b1;
					end else begin
						state_d = ST_ISSUE;
					end
				end
			end
			ST_ISSUE: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (bypass || last) begin
					state_d = ST_OUT;
				end else begin
					ram_raddr = idx_q + 1'b1;
				end
			end
			ST_OUT: begin
				out_ch.valid = 1'b1;
				if (out_ch.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_ch.translated = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_fire && pop_item.cmd != CMD_LOAD) begin
			idx_q    <= '0;
			addr_q   <= pop_item.a;
			dir_q    <= pop_item.cmd;
			result_q <= '0;
		end else if (state_q == ST_EVAL) begin
			idx_q       <= idx_q + 1'b1;
			prev_ge_q   <= ge_k;
			prev_from_q <= from_k;
			prev_to_q   <= to_k;
			result_q    <= result_d;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (idx_q <= last_idx))
		else $error("scan index past last section");

	a_translate_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_fire && pop_item.cmd != CMD_LOAD) |=> (state_q == ST_ISSUE))
		else $error("translate transaction did not start a scan");

	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_ch.ready) |=> (state_q == ST_IDLE))
		else $error("result delivered but back end not idle");

endmodule

>>> hdl/section_address_translate_core.sv
// Top level of the section address translator: front end, queue and back end.
// A load transaction writes one section table entry and is taken by the back end while
// it is idle. A translate transaction (virtual to raw or raw to virtual) scans the table
// one entry per cycle through the table RAM's single read port: it dequeues, reads entry
// 0, evaluates up to N entries, where N is section_count clamped to 1..16, and then
// presents the result until the output handshake completes; an address below entry 0's
// base finishes after the first entry. A two-entry queue keeps accepting transactions
// while a scan runs or a result waits, until it is full.
`timescale 1ns / 1ps

module section_address_translate_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [sat_pkg::CNT_W-1:0] cfg_wr_data,
	sat_in_if.sink                    in_ch,
	sat_out_if.source                 out_ch
);
	import sat_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	sat_front u_front (
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	sat_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	sat_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_ch      (out_ch)
	);

endmodule
